// ----- src/pit_pkg.sv -----
package pit_pkg;

  localparam int MAX_INTERVALS = 64;
  localparam int COUNT_WIDTH   = 48;

  localparam int FRAME_W = 20;
  localparam int OUT_W   = 48;
  localparam int IDX_W   = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CNT_W   = $clog2(MAX_INTERVALS + 1);

  typedef logic [FRAME_W-1:0]     frames_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [OUT_W-1:0]       out_count_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       qcount_t;
  typedef logic [IDX_W:0]         idx_sum_t;

  localparam frames_t DEV_BUF_RESET = frames_t'(1024);

  typedef enum logic [1:0] {
    FUNC_RENDER  = 2'd0,
    FUNC_PADDING = 2'd1,
    FUNC_FLUSH   = 2'd2
  } func_t;

  // One queued interval of real media frames, in device frame numbers.
  typedef struct packed {
    count_t start_frame;
    count_t end_frame;
  } interval_t;

  localparam int INTERVAL_W = $bits(interval_t);

  function automatic count_t sat_add(input count_t a, input count_t b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
  endfunction

  // Wraps a slot sum that is known to stay below twice the queue depth.
  function automatic idx_t wrap_idx(input idx_sum_t v);
    idx_sum_t m;
    m = idx_sum_t'(MAX_INTERVALS);
    return (v >= m) ? idx_t'(v - m) : idx_t'(v);
  endfunction

endpackage

// ----- src/pit_in_if.sv -----
interface pit_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               func;
  logic [pit_pkg::FRAME_W-1:0] padding_frames;
  logic [pit_pkg::FRAME_W-1:0] ring_frames_ready;

  modport source (output valid, func, padding_frames, ring_frames_ready, input ready);
  modport sink   (input valid, func, padding_frames, ring_frames_ready, output ready);
endinterface

// ----- src/pit_out_if.sv -----
interface pit_out_if;
  logic                        valid;
  logic                        ready;
  logic [pit_pkg::OUT_W-1:0]   played_media_frames;
  logic [pit_pkg::OUT_W-1:0]   device_media_frames;
  logic [pit_pkg::OUT_W-1:0]   device_padding_frames;
  logic [pit_pkg::OUT_W-1:0]   submitted_frames;
  logic [pit_pkg::FRAME_W-1:0] copied_frames;
  logic                        interval_overflow;

  modport source (output valid, played_media_frames, device_media_frames,
                  device_padding_frames, submitted_frames, copied_frames,
                  interval_overflow, input ready);
  modport sink   (input valid, played_media_frames, device_media_frames,
                  device_padding_frames, submitted_frames, copied_frames,
                  interval_overflow, output ready);
endinterface

// ----- src/pit_ram.sv -----
module pit_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/played_frame_interval_tracker.sv -----
// Tracks how many real media frames a device has played. Each request is a render
// period, a padding update, a flush or an unused event code, and yields exactly one
// result. Queued media intervals sit in a synchronous RAM with one write and one read
// port (start and end frame per entry); a request walks the head of the queue, reading
// and then checking each visited entry, and a render period then appends the new
// interval with a read of the tail entry. A result that has not yet been taken holds
// the block in its finishing state until the output register frees. A new request is
// taken while the previous result still waits in the output register.
module played_frame_interval_tracker (
  input  logic                         clk,
  input  logic                         rst_n,
  pit_in_if.sink                       in_ch,
  pit_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [pit_pkg::FRAME_W-1:0]  cfg_wdata
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_RET_RD   = 11'b000_0000_0010,
    S_RET_CHK  = 11'b000_0000_0100,
    S_RET_DONE = 11'b000_0000_1000,
    S_APPLY    = 11'b000_0001_0000,
    S_PUSH     = 11'b000_0010_0000,
    S_PUSH_CHK = 11'b000_0100_0000,
    S_PUSH_NEW = 11'b000_1000_0000,
    S_SUBMIT   = 11'b001_0000_0000,
    S_PAD_EST  = 11'b010_0000_0000,
    S_FINISH   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  pit_pkg::frames_t   dev_buf_r;
  pit_pkg::func_t     func_r;
  pit_pkg::frames_t   pad_r;
  pit_pkg::frames_t   ring_r;
  pit_pkg::frames_t   avail_r;
  pit_pkg::frames_t   copied_r;
  pit_pkg::idx_t      head_r;
  pit_pkg::idx_t      tail_r;
  pit_pkg::qcount_t   count_r;
  pit_pkg::count_t    submitted_r;
  pit_pkg::count_t    pad_est_r;
  pit_pkg::count_t    media_r;
  pit_pkg::count_t    played_r;
  pit_pkg::count_t    played_dev_r;
  pit_pkg::count_t    consumed_r;
  pit_pkg::count_t    delta_r;
  pit_pkg::count_t    end_new_r;
  logic               overflow_r;

  logic                   out_valid_r;
  pit_pkg::out_count_t    out_played_r;
  pit_pkg::out_count_t    out_media_r;
  pit_pkg::out_count_t    out_pad_r;
  pit_pkg::out_count_t    out_sub_r;
  pit_pkg::frames_t       out_copied_r;
  logic                   out_ovf_r;

  logic                   ram_we;
  pit_pkg::idx_t          ram_waddr;
  pit_pkg::interval_t     ram_wdata;
  pit_pkg::idx_t          ram_raddr;
  pit_pkg::interval_t     ram_rdata;

  pit_pkg::idx_t          tail_c;
  pit_pkg::idx_t          slot_c;
  pit_pkg::frames_t       avail_c;
  pit_pkg::count_t        ce_c;
  pit_pkg::count_t        est_c;
  logic                   hit_c;
  logic                   lt_pe_c;
  logic                   ce_gt_s_c;
  logic                   tail_match_c;
  logic                   q_full_c;
  logic                   out_free_c;

  pit_ram #(
    .DEPTH (pit_pkg::MAX_INTERVALS),
    .WIDTH (pit_pkg::INTERVAL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.played_media_frames   = out_played_r;
  assign out_ch.device_media_frames   = out_media_r;
  assign out_ch.device_padding_frames = out_pad_r;
  assign out_ch.submitted_frames      = out_sub_r;
  assign out_ch.copied_frames         = out_copied_r;
  assign out_ch.interval_overflow     = out_ovf_r;

  assign out_free_c = !out_valid_r || out_ch.ready;

  assign tail_c = pit_pkg::wrap_idx({1'b0, head_r} + pit_pkg::idx_sum_t'(count_r)
                                    - pit_pkg::idx_sum_t'(1));
  assign slot_c = pit_pkg::wrap_idx({1'b0, head_r} + pit_pkg::idx_sum_t'(count_r));
  assign q_full_c = (count_r >= pit_pkg::qcount_t'(pit_pkg::MAX_INTERVALS));

  // Retire step on the head entry. Once played frames pass the start, the
  // walk stops exactly when the played point lies inside the interval.
  assign hit_c     = (played_dev_r > ram_rdata.start_frame);
  assign lt_pe_c   = (played_dev_r < ram_rdata.end_frame);
  assign ce_c      = lt_pe_c ? played_dev_r : ram_rdata.end_frame;
  assign ce_gt_s_c = lt_pe_c || (ram_rdata.end_frame > ram_rdata.start_frame);

  assign tail_match_c = (ram_rdata.end_frame == submitted_r);

  assign avail_c = (dev_buf_r > pad_r) ? dev_buf_r - pad_r : '0;
  assign est_c   = pit_pkg::count_t'(pad_r) + pit_pkg::count_t'(avail_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head_r;
    ram_wdata = ram_rdata;
    ram_raddr = head_r;
    case (state_r)
      S_RET_CHK: begin
        ram_we    = hit_c;
        ram_waddr = head_r;
        ram_wdata.start_frame = ce_gt_s_c ? ce_c : ram_rdata.start_frame;
        ram_wdata.end_frame   = ram_rdata.end_frame;
      end
      S_PUSH: begin
        ram_raddr = tail_c;
      end
      S_PUSH_CHK: begin
        ram_we    = tail_match_c;
        ram_waddr = tail_r;
        ram_wdata.start_frame = ram_rdata.start_frame;
        ram_wdata.end_frame   = end_new_r;
      end
      S_PUSH_NEW: begin
        ram_we    = !q_full_c;
        ram_waddr = slot_c;
        ram_wdata.start_frame = submitted_r;
        ram_wdata.end_frame   = end_new_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.func == pit_pkg::FUNC_RENDER || in_ch.func == pit_pkg::FUNC_PADDING) begin
            state_nxt = S_RET_RD;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_RET_RD:   state_nxt = (count_r == '0) ? S_RET_DONE : S_RET_CHK;
      S_RET_CHK:  state_nxt = (hit_c && !lt_pe_c) ? S_RET_RD : S_RET_DONE;
      S_RET_DONE: state_nxt = S_APPLY;
      S_APPLY:    state_nxt = (func_r == pit_pkg::FUNC_RENDER) ? S_PUSH : S_FINISH;
      S_PUSH: begin
        if (avail_r == '0) begin
          state_nxt = S_FINISH;
        end else if (copied_r == '0) begin
          state_nxt = S_SUBMIT;
        end else if (count_r == '0) begin
          state_nxt = S_PUSH_NEW;
        end else begin
          state_nxt = S_PUSH_CHK;
        end
      end
      S_PUSH_CHK: state_nxt = tail_match_c ? S_SUBMIT : S_PUSH_NEW;
      S_PUSH_NEW: state_nxt = S_SUBMIT;
      S_SUBMIT:   state_nxt = S_PAD_EST;
      S_PAD_EST:  state_nxt = S_FINISH;
      S_FINISH:   state_nxt = out_free_c ? S_IDLE : S_FINISH;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dev_buf_r   <= pit_pkg::DEV_BUF_RESET;
      head_r      <= '0;
      count_r     <= '0;
      submitted_r <= '0;
      pad_est_r   <= '0;
      media_r     <= '0;
      played_r    <= '0;
      overflow_r  <= 1'b0;
      consumed_r  <= '0;
      delta_r     <= '0;
      copied_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        dev_buf_r <= cfg_wdata;
      end
      if (state_r == S_FINISH && out_free_c) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            func_r     <= pit_pkg::func_t'(in_ch.func);
            pad_r      <= in_ch.padding_frames;
            ring_r     <= in_ch.ring_frames_ready;
            copied_r   <= '0;
            consumed_r <= '0;
            delta_r    <= '0;
            if (in_ch.func == pit_pkg::FUNC_RENDER || in_ch.func == pit_pkg::FUNC_PADDING) begin
              pad_est_r    <= pit_pkg::count_t'(in_ch.padding_frames);
              played_dev_r <= (submitted_r >= pit_pkg::count_t'(in_ch.padding_frames)) ?
                              submitted_r - pit_pkg::count_t'(in_ch.padding_frames) : '0;
            end else if (in_ch.func == pit_pkg::FUNC_FLUSH) begin
              head_r      <= '0;
              count_r     <= '0;
              submitted_r <= '0;
              pad_est_r   <= '0;
              media_r     <= '0;
              played_r    <= '0;
            end
          end
        end
        S_RET_RD, S_RET_DONE: begin
          consumed_r <= pit_pkg::sat_add(consumed_r, delta_r);
          delta_r    <= '0;
        end
        S_RET_CHK: begin
          if (hit_c) begin
            delta_r <= ce_gt_s_c ? ce_c - ram_rdata.start_frame : '0;
            if (!lt_pe_c) begin
              head_r  <= pit_pkg::wrap_idx({1'b0, head_r} + pit_pkg::idx_sum_t'(1));
              count_r <= count_r - pit_pkg::qcount_t'(1);
            end
          end
        end
        S_APPLY: begin
          played_r <= pit_pkg::sat_add(played_r, consumed_r);
          media_r  <= (media_r >= consumed_r) ? media_r - consumed_r : '0;
          if (func_r == pit_pkg::FUNC_RENDER) begin
            avail_r  <= avail_c;
            copied_r <= (ring_r < avail_c) ? ring_r : avail_c;
          end
        end
        S_PUSH: begin
          end_new_r <= pit_pkg::sat_add(submitted_r, pit_pkg::count_t'(copied_r));
          tail_r    <= tail_c;
        end
        S_PUSH_CHK: begin
          if (tail_match_c) begin
            media_r <= pit_pkg::sat_add(media_r, pit_pkg::count_t'(copied_r));
          end
        end
        S_PUSH_NEW: begin
          if (q_full_c) begin
            overflow_r <= 1'b1;
          end else begin
            count_r <= count_r + pit_pkg::qcount_t'(1);
            media_r <= pit_pkg::sat_add(media_r, pit_pkg::count_t'(copied_r));
          end
        end
        S_SUBMIT: begin
          submitted_r <= pit_pkg::sat_add(submitted_r, pit_pkg::count_t'(avail_r));
        end
        S_PAD_EST: begin
          pad_est_r <= (submitted_r < est_c) ? submitted_r : est_c;
        end
        default: begin
        end
      endcase
    end
  end

  // The result payload is loaded as the request completes.
  always_ff @(posedge clk) begin
    if (state_r == S_FINISH && out_free_c) begin
      out_played_r <= pit_pkg::out_count_t'(played_r);
      out_media_r  <= pit_pkg::out_count_t'(media_r);
      out_pad_r    <= pit_pkg::out_count_t'(pad_est_r);
      out_sub_r    <= pit_pkg::out_count_t'(submitted_r);
      out_copied_r <= copied_r;
      out_ovf_r    <= overflow_r;
    end
  end

endmodule
